// ===== rtl/rssi_kalman_distance_tracker_unit_macros.svh =====
// assertion macros used by the tracker back end
`ifndef RSSI_KALMAN_DISTANCE_TRACKER_UNIT_MACROS_SVH
`define RSSI_KALMAN_DISTANCE_TRACKER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on aclk, off during reset
`define RKDT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rkdt assertion failed");
// next-cycle implication, sampled on aclk, off during reset
`define RKDT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rkdt assertion failed");
`else
`define RKDT_ASSERT_IMPL(label, ante, cons)
`define RKDT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/rkdt_pkg.sv =====
package rkdt_pkg;

    // number of tracked bases and index width
    localparam int BASE_COUNT = 3;
    localparam int BASE_W = (BASE_COUNT > 1) ? $clog2(BASE_COUNT) : 1;

    // result status codes
    localparam logic [2:0] ST_ACCEPT  = 3'd0;
    localparam logic [2:0] ST_SHORT   = 3'd1;
    localparam logic [2:0] ST_COMPANY = 3'd2;
    localparam logic [2:0] ST_RANGE   = 3'd3;
    localparam logic [2:0] ST_TICK    = 3'd4;

    // register indexes
    localparam logic [2:0] REG_COMPANY = 3'd0;
    localparam logic [2:0] REG_PNOISE  = 3'd1;
    localparam logic [2:0] REG_MNOISE  = 3'd2;
    localparam logic [2:0] REG_EXPON   = 3'd3;
    localparam logic [2:0] REG_TIMEOUT = 3'd4;

    // register reset values
    localparam logic [15:0] COMPANY_RESET = 16'd89;
    localparam logic [23:0] PNOISE_RESET  = 24'd655;
    localparam logic [23:0] MNOISE_RESET  = 24'd131072;
    localparam logic [10:0] EXPON_RESET   = 11'd512;
    localparam logic [31:0] TIMEOUT_RESET = 32'd5000;

    // per-base state reset values
    localparam logic signed [15:0] EST_RESET = -16'sd17920;
    localparam logic [23:0]        VAR_RESET = 24'd131072;

    // distance constants
    localparam logic [23:0] DIST_MAX      = 24'hFFFFFF;
    localparam logic [23:0] DIST_MIN_CODE = 24'd3;
    localparam logic [17:0] LOG2_10_Q16   = 18'd217706;
    localparam logic [5:0]  DIV_STEPS     = 6'd40;

    typedef struct packed {
        logic [15:0] company_id_match;
        logic [23:0] process_noise;
        logic [23:0] measurement_noise;
        logic [10:0] path_loss_exponent;
        logic [31:0] stale_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [31:0]       time_ms;
        logic [BASE_W-1:0] base;
        logic signed [7:0] tx_power;
        logic signed [7:0] rssi;
    } item_t;

    typedef logic [15:0][30:0] root_arr_t;

    // integer square root, used at elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] b;
        n = v;
        res = 64'd0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // roots 2^(2^-k), k = 1..16, in Q1.30
    function automatic root_arr_t make_roots();
        root_arr_t t;
        logic [63:0] r;
        r = 64'h8000_0000;
        for (int k = 0; k < 16; k++) begin
            r = isqrt64(r << 30);
            t[k] = r[30:0];
        end
        return t;
    endfunction

    localparam root_arr_t ROOTS = make_roots();

endpackage

// ===== rtl/rkdt_regs.sv =====
module rkdt_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output rkdt_pkg::cfg_t     cfg
);

    rkdt_pkg::cfg_t cfg_reg;

    assign pready = 1'b1;
    assign cfg = cfg_reg;

    // register writes on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.company_id_match   <= rkdt_pkg::COMPANY_RESET;
            cfg_reg.process_noise      <= rkdt_pkg::PNOISE_RESET;
            cfg_reg.measurement_noise  <= rkdt_pkg::MNOISE_RESET;
            cfg_reg.path_loss_exponent <= rkdt_pkg::EXPON_RESET;
            cfg_reg.stale_timeout_ms   <= rkdt_pkg::TIMEOUT_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                rkdt_pkg::REG_COMPANY: cfg_reg.company_id_match   <= pwdata[15:0];
                rkdt_pkg::REG_PNOISE:  cfg_reg.process_noise      <= pwdata[23:0];
                rkdt_pkg::REG_MNOISE:  cfg_reg.measurement_noise  <= pwdata[23:0];
                rkdt_pkg::REG_EXPON:   cfg_reg.path_loss_exponent <= pwdata[10:0];
                rkdt_pkg::REG_TIMEOUT: cfg_reg.stale_timeout_ms   <= pwdata;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (paddr[4:2])
            rkdt_pkg::REG_COMPANY: prdata = {16'd0, cfg_reg.company_id_match};
            rkdt_pkg::REG_PNOISE:  prdata = {8'd0, cfg_reg.process_noise};
            rkdt_pkg::REG_MNOISE:  prdata = {8'd0, cfg_reg.measurement_noise};
            rkdt_pkg::REG_EXPON:   prdata = {21'd0, cfg_reg.path_loss_exponent};
            rkdt_pkg::REG_TIMEOUT: prdata = cfg_reg.stale_timeout_ms;
            default:               prdata = 32'd0;
        endcase
    end

endmodule

// ===== rtl/rkdt_front.sv =====
module rkdt_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  rkdt_pkg::cfg_t      cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_operation,
    input  logic [31:0]         s_time_ms,
    input  logic [7:0]          s_payload_length,
    input  logic [15:0]         s_company_id,
    input  logic [7:0]          s_base_number,
    input  logic signed [7:0]   s_tx_power_1m,
    input  logic signed [7:0]   s_received_rssi,
    output logic                q_valid,
    input  logic                q_ready,
    output rkdt_pkg::item_t     q_item
);

    rkdt_pkg::item_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      fill_reg;
    rkdt_pkg::item_t new_item;
    logic            push;
    logic            pop;

    // classify the incoming beat
    always_comb begin
        new_item.time_ms  = s_time_ms;
        new_item.base     = s_base_number[rkdt_pkg::BASE_W-1:0];
        new_item.tx_power = s_tx_power_1m;
        new_item.rssi     = s_received_rssi;
        if (s_operation) begin
            new_item.status = rkdt_pkg::ST_TICK;
        end else if (s_payload_length < 8'd4) begin
            new_item.status = rkdt_pkg::ST_SHORT;
        end else if (s_company_id != cfg.company_id_match) begin
            new_item.status = rkdt_pkg::ST_COMPANY;
        end else if (s_base_number >= 8'(rkdt_pkg::BASE_COUNT)) begin
            new_item.status = rkdt_pkg::ST_RANGE;
        end else begin
            new_item.status = rkdt_pkg::ST_ACCEPT;
        end
    end

    // two-entry queue toward the back end
    assign s_ready = (fill_reg != 2'd2);
    assign q_valid = (fill_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ===== rtl/rkdt_back.sv =====
`include "rssi_kalman_distance_tracker_unit_macros.svh"

module rkdt_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  rkdt_pkg::cfg_t      cfg,
    input  logic                q_valid,
    output logic                q_ready,
    input  rkdt_pkg::item_t     q_item,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output logic [3:0]          m_base_out,
    output logic signed [15:0]  m_filtered_rssi,
    output logic [23:0]         m_distance,
    output logic [15:0]         m_stale_mask,
    output logic [4:0]          m_valid_count,
    output logic                m_all_valid
);

    typedef enum logic [3:0] {
        S_IDLE, S_PRED, S_KDIV, S_KGET, S_KMUL, S_KUPD, S_DMUL, S_DDIV,
        S_DSIGN, S_DCHK, S_EXP, S_ROUND, S_FIN, S_WAIT
    } state_t;

    localparam int BC = rkdt_pkg::BASE_COUNT;

    state_t state_reg;

    // per-base state
    logic signed [15:0] est_reg  [BC];
    logic [23:0]        var_reg  [BC];
    logic [31:0]        seen_reg [BC];
    logic [BC-1:0]      valid_reg;

    // working registers
    rkdt_pkg::item_t    it_reg;
    logic [23:0]        p_reg;
    logic signed [15:0] est_old_reg;
    logic signed [16:0] innov_reg;
    logic [16:0]        k_reg;
    logic signed [34:0] prod_reg;
    logic               neg_reg;
    logic [16:0]        absd_reg;
    logic signed [16:0] ip_reg;
    logic [15:0]        fr_reg;
    logic [30:0]        mant_reg;
    logic [3:0]         exp_cnt_reg;

    // shared divider
    logic [39:0]        dvd_reg;
    logic [24:0]        rem_reg;
    logic [24:0]        dvs_reg;
    logic [5:0]         cnt_reg;

    // pending result
    logic [2:0]         res_status_reg;
    logic [3:0]         res_base_reg;
    logic signed [15:0] res_filt_reg;
    logic [23:0]        res_dist_reg;
    logic [15:0]        res_mask_reg;

    // output register
    logic               m_valid_reg;
    logic [2:0]         m_status_reg;
    logic [3:0]         m_base_reg;
    logic signed [15:0] m_filt_reg;
    logic [23:0]        m_distance_reg;
    logic [15:0]        m_mask_reg;
    logic [4:0]         m_count_reg;
    logic               m_all_reg;

    // combinational helpers
    logic [BC-1:0]      stale;
    logic [4:0]         vcount;
    logic [24:0]        p_sum;
    logic [23:0]        p_sat;
    logic [24:0]        den;
    logic signed [16:0] innov;
    logic [25:0]        trial;
    logic               trial_ge;
    logic [25:0]        trial_sub;
    logic signed [34:0] kprod;
    logic signed [34:0] rnd;
    logic signed [19:0] est_wide;
    logic signed [15:0] est_new;
    logic [40:0]        vprod;
    logic signed [17:0] tdiff;
    logic [34:0]        dprod;
    logic [10:0]        n_eff;
    logic [14:0]        ten_n;
    logic [32:0]        q33;
    logic signed [32:0] y_val;
    logic [61:0]        mprod;
    logic signed [16:0] sh_w;
    logic [5:0]         sh;
    logic [39:0]        rounded;

    assign q_ready = (state_reg == S_IDLE);

    // staleness and valid count
    always_comb begin
        vcount = 5'd0;
        for (int i = 0; i < BC; i++) begin
            stale[i] = valid_reg[i] &&
                       ((q_item.time_ms - seen_reg[i]) > cfg.stale_timeout_ms);
            vcount = vcount + 5'(valid_reg[i]);
        end
    end

    // predict and gain denominator
    assign p_sum = {1'b0, var_reg[it_reg.base]} + {1'b0, cfg.process_noise};
    assign p_sat = p_sum[24] ? 24'hFFFFFF : p_sum[23:0];
    assign den   = {1'b0, p_sat} + {1'b0, cfg.measurement_noise};
    assign innov = $signed({it_reg.rssi[7], it_reg.rssi, 8'd0})
                 - $signed({est_reg[it_reg.base][15], est_reg[it_reg.base]});

    // restoring divider step
    assign trial     = {rem_reg, dvd_reg[39]};
    assign trial_ge  = (trial >= {1'b0, dvs_reg});
    assign trial_sub = trial - {1'b0, dvs_reg};

    // estimate update
    assign kprod = $signed({1'b0, k_reg}) * innov_reg;
    assign rnd   = prod_reg + 35'sd32768;
    assign est_wide = $signed({{4{est_old_reg[15]}}, est_old_reg})
                    + $signed({rnd[34], rnd[34:16]});
    always_comb begin
        if (est_wide > 20'sd32767) begin
            est_new = 16'sh7FFF;
        end else if (est_wide < -20'sd32768) begin
            est_new = 16'sh8000;
        end else begin
            est_new = est_wide[15:0];
        end
    end
    assign vprod = 41'(17'h10000 - k_reg) * 41'(p_reg);

    // path loss exponent term
    assign tdiff = $signed({{2{it_reg.tx_power[7]}}, it_reg.tx_power, 8'd0})
                 - $signed({{2{est_new[15]}}, est_new});
    assign dprod = 35'(absd_reg) * 35'(rkdt_pkg::LOG2_10_Q16);
    assign n_eff = (cfg.path_loss_exponent == 11'd0) ? 11'd1 : cfg.path_loss_exponent;
    assign ten_n = 15'({n_eff, 3'd0}) + 15'({n_eff, 1'd0});
    assign q33   = dvd_reg[32:0];
    assign y_val = neg_reg ? $signed(33'd0 - (q33 + 33'(rem_reg != 25'd0))) : $signed(q33);

    // fraction power and rounding
    assign mprod   = 62'(mant_reg) * 62'(rkdt_pkg::ROOTS[exp_cnt_reg]);
    assign sh_w    = 17'sd22 - ip_reg;
    assign sh      = sh_w[5:0];
    assign rounded = ({9'd0, mant_reg} + (40'd1 << (sh - 6'd1))) >> sh;

    // sequencer, per-base state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            valid_reg   <= '0;
            for (int i = 0; i < BC; i++) begin
                est_reg[i]  <= rkdt_pkg::EST_RESET;
                var_reg[i]  <= rkdt_pkg::VAR_RESET;
                seen_reg[i] <= 32'd0;
            end
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        it_reg         <= q_item;
                        res_status_reg <= q_item.status;
                        res_base_reg   <= 4'd0;
                        res_filt_reg   <= 16'sd0;
                        res_dist_reg   <= 24'd0;
                        res_mask_reg   <= 16'd0;
                        case (q_item.status)
                            rkdt_pkg::ST_TICK: begin
                                valid_reg    <= valid_reg & ~stale;
                                res_mask_reg <= 16'(stale);
                                state_reg    <= S_FIN;
                            end
                            rkdt_pkg::ST_ACCEPT: state_reg <= S_PRED;
                            default:             state_reg <= S_FIN;
                        endcase
                    end
                end
                S_PRED: begin
                    p_reg       <= p_sat;
                    est_old_reg <= est_reg[it_reg.base];
                    innov_reg   <= innov;
                    if (den == 25'd0) begin
                        k_reg     <= 17'd0;
                        state_reg <= S_KMUL;
                    end else begin
                        dvd_reg   <= {p_sat, 16'd0};
                        rem_reg   <= 25'd0;
                        dvs_reg   <= den;
                        cnt_reg   <= 6'd0;
                        state_reg <= S_KDIV;
                    end
                end
                S_KDIV, S_DDIV: begin
                    rem_reg <= trial_ge ? trial_sub[24:0] : trial[24:0];
                    dvd_reg <= {dvd_reg[38:0], trial_ge};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == rkdt_pkg::DIV_STEPS - 6'd1) begin
                        state_reg <= (state_reg == S_KDIV) ? S_KGET : S_DSIGN;
                    end
                end
                S_KGET: begin
                    k_reg     <= dvd_reg[16:0];
                    state_reg <= S_KMUL;
                end
                S_KMUL: begin
                    prod_reg  <= kprod;
                    state_reg <= S_KUPD;
                end
                S_KUPD: begin
                    est_reg[it_reg.base]   <= est_new;
                    var_reg[it_reg.base]   <= vprod[39:16];
                    seen_reg[it_reg.base]  <= it_reg.time_ms;
                    valid_reg[it_reg.base] <= 1'b1;
                    res_base_reg <= 4'(it_reg.base);
                    res_filt_reg <= est_new;
                    neg_reg      <= tdiff[17];
                    absd_reg     <= tdiff[17] ? 17'(-tdiff) : tdiff[16:0];
                    if (!est_new[15]) begin
                        res_dist_reg <= rkdt_pkg::DIST_MIN_CODE;
                        state_reg    <= S_FIN;
                    end else begin
                        state_reg <= S_DMUL;
                    end
                end
                S_DMUL: begin
                    dvd_reg   <= 40'(dprod);
                    rem_reg   <= 25'd0;
                    dvs_reg   <= 25'(ten_n);
                    cnt_reg   <= 6'd0;
                    state_reg <= S_DDIV;
                end
                S_DSIGN: begin
                    ip_reg    <= y_val[32:16];
                    fr_reg    <= y_val[15:0];
                    state_reg <= S_DCHK;
                end
                S_DCHK: begin
                    if (ip_reg >= 17'sd16) begin
                        res_dist_reg <= rkdt_pkg::DIST_MAX;
                        state_reg    <= S_FIN;
                    end else if (ip_reg <= -17'sd18) begin
                        res_dist_reg <= 24'd0;
                        state_reg    <= S_FIN;
                    end else begin
                        mant_reg    <= 31'h4000_0000;
                        exp_cnt_reg <= 4'd0;
                        state_reg   <= S_EXP;
                    end
                end
                S_EXP: begin
                    if (fr_reg[4'd15 - exp_cnt_reg]) begin
                        mant_reg <= mprod[60:30];
                    end
                    exp_cnt_reg <= exp_cnt_reg + 4'd1;
                    if (exp_cnt_reg == 4'd15) begin
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    res_dist_reg <= (rounded > 40'(rkdt_pkg::DIST_MAX)) ?
                                    rkdt_pkg::DIST_MAX : rounded[23:0];
                    state_reg    <= S_FIN;
                end
                S_FIN: begin
                    m_valid_reg    <= 1'b1;
                    m_status_reg   <= res_status_reg;
                    m_base_reg     <= res_base_reg;
                    m_filt_reg     <= res_filt_reg;
                    m_distance_reg <= res_dist_reg;
                    m_mask_reg     <= res_mask_reg;
                    m_count_reg    <= vcount;
                    m_all_reg      <= (vcount == 5'(BC));
                    state_reg      <= S_WAIT;
                end
                S_WAIT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_base_out      = m_base_reg;
    assign m_filtered_rssi = m_filt_reg;
    assign m_distance      = m_distance_reg;
    assign m_stale_mask    = m_mask_reg;
    assign m_valid_count   = m_count_reg;
    assign m_all_valid     = m_all_reg;

    // checks
    `RKDT_ASSERT_IMPL(a_valid_only_in_wait, m_valid_reg, state_reg == S_WAIT)
    `RKDT_ASSERT_NEXT(a_fin_shows_result, state_reg == S_FIN, m_valid_reg)
    `RKDT_ASSERT_IMPL(a_reject_no_payload, m_valid_reg && (m_status_reg != rkdt_pkg::ST_ACCEPT), (m_distance_reg == 24'd0) && (m_base_reg == 4'd0))
    `RKDT_ASSERT_IMPL(a_mask_only_on_tick, m_valid_reg && (m_status_reg != rkdt_pkg::ST_TICK), m_mask_reg == 16'd0)

endmodule

// ===== rtl/rssi_kalman_distance_tracker_unit.sv =====
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  operation, time, payload length, ids, powers
// m_        out        m_valid / m_ready  status, base, filtered rssi, distance, counts
// apb       in         psel / penable     five configuration registers at 4*i
//
// a tick or a rejected report goes from the queue head through S_IDLE and S_FIN to the result
// an accepted report runs up to two 40-step divider passes (gain, then exponent)
// and a 16-step root multiply loop before its result
// a two-entry queue takes new beats while the back end works or waits on m_ready, until it is full
// synchronous active-low reset empties the queue, resets the bases and loads the register reset values
module rssi_kalman_distance_tracker_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic [31:0]        s_time_ms,
    input  logic [7:0]         s_payload_length,
    input  logic [15:0]        s_company_id,
    input  logic [7:0]         s_base_number,
    input  logic signed [7:0]  s_tx_power_1m,
    input  logic signed [7:0]  s_received_rssi,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [3:0]         m_base_out,
    output logic signed [15:0] m_filtered_rssi,
    output logic [23:0]        m_distance,
    output logic [15:0]        m_stale_mask,
    output logic [4:0]         m_valid_count,
    output logic               m_all_valid
);

    rkdt_pkg::cfg_t  cfg;
    rkdt_pkg::item_t q_item;
    logic            q_valid;
    logic            q_ready;

    // configuration registers
    rkdt_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // accept, classify, queue
    rkdt_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_time_ms        (s_time_ms),
        .s_payload_length (s_payload_length),
        .s_company_id     (s_company_id),
        .s_base_number    (s_base_number),
        .s_tx_power_1m    (s_tx_power_1m),
        .s_received_rssi  (s_received_rssi),
        .q_valid          (q_valid),
        .q_ready          (q_ready),
        .q_item           (q_item)
    );

    // filter, distance, staleness
    rkdt_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_item          (q_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_base_out      (m_base_out),
        .m_filtered_rssi (m_filtered_rssi),
        .m_distance      (m_distance),
        .m_stale_mask    (m_stale_mask),
        .m_valid_count   (m_valid_count),
        .m_all_valid     (m_all_valid)
    );

endmodule

// ===== sim/tb_rssi_kalman_distance_tracker_unit.sv =====
module tb_rssi_kalman_distance_tracker_unit;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 1250;

    typedef struct {
        logic        operation;
        logic [31:0] time_ms;
        logic [7:0]  payload_length;
        logic [15:0] company_id;
        logic [7:0]  base_number;
        logic [7:0]  tx_power;
        logic [7:0]  rssi;
    } report_t;

    typedef struct {
        logic [2:0]  status;
        logic [3:0]  base_out;
        logic [15:0] filtered_rssi;
        logic [23:0] distance;
        logic [15:0] stale_mask;
        logic [4:0]  valid_count;
        logic        all_valid;
    } track_t;

    // directed row: beat plus an optional typed-in expectation
    typedef struct {
        report_t beat;
        bit      has_fixed;
        track_t  fixed;
    } row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_operation = 1'b0;
    logic [31:0]        s_time_ms = '0;
    logic [7:0]         s_payload_length = '0;
    logic [15:0]        s_company_id = '0;
    logic [7:0]         s_base_number = '0;
    logic signed [7:0]  s_tx_power_1m = '0;
    logic signed [7:0]  s_received_rssi = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [2:0]         m_status;
    logic [3:0]         m_base_out;
    logic signed [15:0] m_filtered_rssi;
    logic [23:0]        m_distance;
    logic [15:0]        m_stale_mask;
    logic [4:0]         m_valid_count;
    logic               m_all_valid;

    rssi_kalman_distance_tracker_unit dut (.*);

    always #5 aclk = ~aclk;

    // predictor copy of registers and base state
    logic [15:0]        cfg_company;
    logic [23:0]        cfg_pnoise;
    logic [23:0]        cfg_mnoise;
    logic [10:0]        cfg_expon;
    logic [31:0]        cfg_timeout;
    logic signed [15:0] est_q [rkdt_pkg::BASE_COUNT];
    logic [23:0]        var_q [rkdt_pkg::BASE_COUNT];
    logic [31:0]        seen_q [rkdt_pkg::BASE_COUNT];
    bit                 live_q [rkdt_pkg::BASE_COUNT];

    track_t pending_tracks[$];
    int     fail_count = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     idle_cycles = 0;
    logic [63:0] root_tab [17];

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && ((a < 0) != (b < 0))) q--;
        return q;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] n, res, b;
        n = v;
        res = 64'd0;
        b = 64'h4000_0000_0000_0000;
        while (b > n) b = b >> 2;
        while (b != 64'd0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [23:0] range_of(longint tx, longint est);
        longint n, y, ip, fr, sh;
        logic [63:0] mant;
        n = (cfg_expon == 11'd0) ? 64'sd1 : longint'(cfg_expon);
        if (est >= 0) return rkdt_pkg::DIST_MIN_CODE;
        y = floor_div((tx * 256 - est) * 217706, 10 * n);
        ip = floor_div(y, 65536);
        fr = y - ip * 65536;
        if (ip + 8 >= 24) return rkdt_pkg::DIST_MAX;
        mant = 64'd1 << 30;
        for (int k = 1; k <= 16; k++)
            if (((fr >> (16 - k)) & 1) != 0) mant = (mant * root_tab[k]) >> 30;
        sh = 22 - ip;
        if (sh >= 40) return 24'd0;
        mant = (mant + (64'd1 << (sh - 1))) >> sh;
        return (mant > 64'(rkdt_pkg::DIST_MAX)) ? rkdt_pkg::DIST_MAX : mant[23:0];
    endfunction

    function automatic void reset_tracker();
        cfg_company = rkdt_pkg::COMPANY_RESET;
        cfg_pnoise  = rkdt_pkg::PNOISE_RESET;
        cfg_mnoise  = rkdt_pkg::MNOISE_RESET;
        cfg_expon   = rkdt_pkg::EXPON_RESET;
        cfg_timeout = rkdt_pkg::TIMEOUT_RESET;
        for (int i = 0; i < rkdt_pkg::BASE_COUNT; i++) begin
            est_q[i] = rkdt_pkg::EST_RESET;
            var_q[i] = rkdt_pkg::VAR_RESET;
            seen_q[i] = 32'd0;
            live_q[i] = 1'b0;
        end
    endfunction

    // one Kalman / staleness step of the tracker
    function automatic track_t track_step(report_t r);
        track_t t;
        int cnt;
        int b;
        longint p, den, kg, innov, est;
        t = '{default: 0};
        if (r.operation) begin
            t.status = rkdt_pkg::ST_TICK;
            for (int i = 0; i < rkdt_pkg::BASE_COUNT; i++) begin
                if (live_q[i] && (r.time_ms - seen_q[i]) > cfg_timeout) begin
                    live_q[i] = 1'b0;
                    t.stale_mask[i] = 1'b1;
                end
            end
        end else if (r.payload_length < 8'd4) begin
            t.status = rkdt_pkg::ST_SHORT;
        end else if (r.company_id != cfg_company) begin
            t.status = rkdt_pkg::ST_COMPANY;
        end else if (r.base_number >= 8'(rkdt_pkg::BASE_COUNT)) begin
            t.status = rkdt_pkg::ST_RANGE;
        end else begin
            b = int'(r.base_number);
            t.status = rkdt_pkg::ST_ACCEPT;
            t.base_out = 4'(b);
            seen_q[b] = r.time_ms;
            live_q[b] = 1'b1;
            p = longint'(var_q[b]) + longint'(cfg_pnoise);
            if (p > 64'sh00FF_FFFF) p = 64'sh00FF_FFFF;
            den = p + longint'(cfg_mnoise);
            kg = (den != 0) ? (p <<< 16) / den : 64'sd0;
            innov = longint'($signed(r.rssi)) * 256 - longint'(est_q[b]);
            est = longint'(est_q[b]) + floor_div(kg * innov + 32768, 65536);
            if (est > 32767) est = 32767;
            if (est < -32768) est = -32768;
            est_q[b] = 16'(est);
            var_q[b] = 24'(((65536 - kg) * p) >>> 16);
            t.filtered_rssi = 16'(est);
            t.distance = range_of(longint'($signed(r.tx_power)), est);
        end
        cnt = 0;
        for (int i = 0; i < rkdt_pkg::BASE_COUNT; i++) if (live_q[i]) cnt++;
        t.valid_count = 5'(cnt);
        t.all_valid = (cnt == rkdt_pkg::BASE_COUNT);
        return t;
    endfunction

    // apb write, only while the block is idle
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            rkdt_pkg::REG_COMPANY: cfg_company = val[15:0];
            rkdt_pkg::REG_PNOISE:  cfg_pnoise  = val[23:0];
            rkdt_pkg::REG_MNOISE:  cfg_mnoise  = val[23:0];
            rkdt_pkg::REG_EXPON:   cfg_expon   = val[10:0];
            rkdt_pkg::REG_TIMEOUT: cfg_timeout = val;
            default: ;
        endcase
    endtask

    // send one beat, record its expectation
    task automatic send_beat(report_t r, bit has_fixed, track_t fixed);
        track_t t;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= r.operation;
        s_time_ms <= r.time_ms;
        s_payload_length <= r.payload_length;
        s_company_id <= r.company_id;
        s_base_number <= r.base_number;
        s_tx_power_1m <= r.tx_power;
        s_received_rssi <= r.rssi;
        t = track_step(r);
        if (has_fixed) begin
            pending_tracks.push_back(fixed);
        end else begin
            pending_tracks.push_back(t);
        end
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_tracks.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    function automatic report_t rand_report();
        report_t r;
        int kind;
        kind = int'($urandom_range(99));
        r.operation = (kind < 12);
        r.time_ms = $urandom();
        r.payload_length = 8'((kind < 90) ? $urandom_range(255, 4) : $urandom_range(255));
        r.company_id = (kind < 80) ? cfg_company : 16'($urandom());
        r.base_number = 8'((kind < 75) ? $urandom_range(rkdt_pkg::BASE_COUNT - 1)
                                       : $urandom_range(255));
        r.tx_power = 8'($urandom());
        r.rssi = 8'($urandom());
        return r;
    endfunction

    // receiver side: random stalls and field checks
    always @(posedge aclk) begin
        track_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_tracks.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end else begin
                    e = pending_tracks.pop_front();
                    if (m_status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, m_status); fail_count++;
                    end
                    if (m_base_out !== e.base_out) begin
                        $error("base_out exp %0d got %0d", e.base_out, m_base_out);
                        fail_count++;
                    end
                    if (m_filtered_rssi !== e.filtered_rssi) begin
                        $error("filtered_rssi exp %0d got %0d",
                            $signed(e.filtered_rssi), m_filtered_rssi);
                        fail_count++;
                    end
                    if (m_distance !== e.distance) begin
                        $error("distance exp %0d got %0d", e.distance, m_distance);
                        fail_count++;
                    end
                    if (m_stale_mask !== e.stale_mask) begin
                        $error("stale_mask exp %h got %h", e.stale_mask, m_stale_mask);
                        fail_count++;
                    end
                    if (m_valid_count !== e.valid_count) begin
                        $error("valid_count exp %0d got %0d", e.valid_count, m_valid_count);
                        fail_count++;
                    end
                    if (m_all_valid !== e.all_valid) begin
                        $error("all_valid exp %0d got %0d", e.all_valid, m_all_valid);
                        fail_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no beat moving and no apb access
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic report_t mk(logic op, logic [31:0] tm, logic [7:0] len,
                                   logic [15:0] cid, logic [7:0] bn,
                                   logic [7:0] tx, logic [7:0] rs);
        report_t r;
        r = '{op, tm, len, cid, bn, tx, rs};
        return r;
    endfunction

    function automatic track_t rej(logic [2:0] st, logic [4:0] cnt);
        track_t t;
        t = '{default: 0};
        t.status = st;
        t.valid_count = cnt;
        return t;
    endfunction

    initial begin
        row_t   rows[$];
        track_t none;
        logic [63:0] rt;
        none = '{default: 0};
        rt = 64'd1 << 31;
        for (int k = 1; k <= 16; k++) begin
            rt = int_sqrt(rt << 30);
            root_tab[k] = rt;
        end
        reset_tracker();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        rows.push_back('{mk(1'b1, 32'd0, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0), 1'b1,
                         rej(rkdt_pkg::ST_TICK, 5'd0)});
        rows.push_back('{mk(1'b0, 32'd1, 8'd0, 16'd89, 8'd0, 8'd0, 8'd0), 1'b1,
                         rej(rkdt_pkg::ST_SHORT, 5'd0)});
        rows.push_back('{mk(1'b0, 32'd1, 8'd3, 16'd89, 8'd0, 8'd0, 8'd0), 1'b1,
                         rej(rkdt_pkg::ST_SHORT, 5'd0)});
        rows.push_back('{mk(1'b0, 32'd1, 8'd255, 16'hFFFF, 8'd0, 8'd0, 8'd0), 1'b1,
                         rej(rkdt_pkg::ST_COMPANY, 5'd0)});
        rows.push_back('{mk(1'b0, 32'd1, 8'd4, 16'd89, 8'd3, 8'd0, 8'd0), 1'b1,
                         rej(rkdt_pkg::ST_RANGE, 5'd0)});
        rows.push_back('{mk(1'b0, 32'd1, 8'd4, 16'd89, 8'd255, 8'd0, 8'd0), 1'b1,
                         rej(rkdt_pkg::ST_RANGE, 5'd0)});
        rows.push_back('{mk(1'b0, 32'd100, 8'd4, 16'd89, 8'd0, 8'hC5, 8'hC0), 1'b0, none});
        rows.push_back('{mk(1'b0, 32'd200, 8'd255, 16'd89, 8'd1, 8'h7F, 8'h80), 1'b0, none});
        rows.push_back('{mk(1'b0, 32'd300, 8'd4, 16'd89, 8'd2, 8'h80, 8'h7F), 1'b0, none});
        rows.push_back('{mk(1'b0, 32'd400, 8'd4, 16'd89, 8'd2, 8'h80, 8'h7F), 1'b0, none});
        rows.push_back('{mk(1'b0, 32'd500, 8'd4, 16'd89, 8'd0, 8'h00, 8'h00), 1'b0, none});
        rows.push_back('{mk(1'b1, 32'd5100, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0), 1'b0, none});
        rows.push_back('{mk(1'b1, 32'd5300, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0), 1'b0, none});
        rows.push_back('{mk(1'b1, 32'hFFFF_FFFF, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0), 1'b0,
                         none});
        rows.push_back('{mk(1'b0, 32'hFFFF_FF00, 8'd4, 16'd89, 8'd1, 8'hD8, 8'hA0), 1'b0,
                         none});
        rows.push_back('{mk(1'b1, 32'd100, 8'd0, 16'd0, 8'd0, 8'd0, 8'd0), 1'b0, none});
        foreach (rows[i]) send_beat(rows[i].beat, rows[i].has_fixed, rows[i].fixed);
        drain();

        // random phases across register settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    reg_write(rkdt_pkg::REG_COMPANY, 32'h0000_FFFF);
                    reg_write(rkdt_pkg::REG_PNOISE, 32'd0);
                    reg_write(rkdt_pkg::REG_MNOISE, 32'd1);
                    reg_write(rkdt_pkg::REG_EXPON, 32'd256);
                    reg_write(rkdt_pkg::REG_TIMEOUT, 32'd0);
                end
                1: begin
                    reg_write(rkdt_pkg::REG_COMPANY, 32'd0);
                    reg_write(rkdt_pkg::REG_PNOISE, 32'h00FF_FFFF);
                    reg_write(rkdt_pkg::REG_MNOISE, 32'h00FF_FFFF);
                    reg_write(rkdt_pkg::REG_EXPON, 32'd2047);
                    reg_write(rkdt_pkg::REG_TIMEOUT, 32'hFFFF_FFFF);
                end
                2: begin
                    reg_write(rkdt_pkg::REG_PNOISE, 32'd0);
                    reg_write(rkdt_pkg::REG_MNOISE, 32'd0);
                    reg_write(rkdt_pkg::REG_EXPON, 32'd0);
                end
                default: begin
                    reg_write(rkdt_pkg::REG_COMPANY, $urandom());
                    reg_write(rkdt_pkg::REG_PNOISE, $urandom_range(32'h00FF_FFFF));
                    reg_write(rkdt_pkg::REG_MNOISE, $urandom_range(32'h00FF_FFFF, 1));
                    reg_write(rkdt_pkg::REG_EXPON, $urandom_range(2047, 256));
                    reg_write(rkdt_pkg::REG_TIMEOUT, $urandom());
                end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
                if (n == 0) begin
                    send_idle_pct = 24; recv_idle_pct = 86;
                end else if (n == RANDOM_ITEMS / 18) begin
                    send_idle_pct = 86; recv_idle_pct = 24;
                end else if (n == RANDOM_ITEMS / 9) begin
                    send_idle_pct = 0; recv_idle_pct = 0;
                end
                send_beat(rand_report(), 1'b0, none);
            end
            send_idle_pct = 0; recv_idle_pct = 0;
            drain();
        end

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // expectations should never pile up beyond 64 outstanding results
    always @(posedge aclk) begin
        if (aresetn && pending_tracks.size() > 64) begin
            $error("too many results outstanding");
            fail_count++;
        end
    end

endmodule
